// ===== hw/rtl/prw3x3_pkg.sv =====
// shared constants for the 3x3 edge filter
// no dependencies
`default_nettype none

package prw3x3_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int MIN_SIZE      = 3;

	localparam int PIX_W     = 8;
	localparam int FWIDTH_W  = 11;
	localparam int FHEIGHT_W = 13;
	localparam int ROW_W     = 12;
	localparam int SIZE_W    = 13;
	localparam int SUM_W     = 12;

	localparam logic [FWIDTH_W-1:0]  RST_FRAME_WIDTH  = FWIDTH_W'(25);
	localparam logic [FHEIGHT_W-1:0] RST_FRAME_HEIGHT = FHEIGHT_W'(25);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prewitt_3x3_edge_filter_top.sv =====
// 3x3 prewitt edge filter over a raster pixel stream, top level
// uses prw3x3_pkg and two prw3x3_ram line stores
//
// input stream: tdata carries one 8-bit pixel, tuser marks the first pixel of
// a frame (row 0, column 0). pixels arrive in raster order.
// output stream: one 8-bit edge value per interior pixel position, tlast on
// the last interior result of the frame. border positions give no output.
// config channel: cfg_index 0 writes frame_width, 1 writes frame_height;
// always ready, write only while the stream is idle. sizes are clamped to
// 3..MAX_WIDTH and 3..4096. after the last pixel of a frame the position
// counters wrap on their own.
// throughput: one pixel per clock while the receiver keeps up. a pixel is
// registered in the input stage with the line store read, and its result in
// the output register. when the receiver stalls, one result waits in the
// output register and one pixel in the input stage, then s_axis_tready drops.
// reset clears counters, window and valid flags and loads 25x25; the line
// stores need no clearing.
`default_nettype none

module prewitt_3x3_edge_filter_top #(
	parameter int MAX_WIDTH = prw3x3_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [7:0]                        s_axis_tdata,  // [7:0] pixel
	input  wire logic                              s_axis_tuser,  // [0] frame_start
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic      [7:0]                        m_axis_tdata,  // [7:0] edge_res
	output logic                                   m_axis_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [prw3x3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [prw3x3_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = prw3x3_pkg::PIX_W;
	localparam int ZW = prw3x3_pkg::SIZE_W;
	localparam int RW = prw3x3_pkg::ROW_W;
	localparam int SW = prw3x3_pkg::SUM_W;

	logic [prw3x3_pkg::FWIDTH_W-1:0]  frame_width_q;
	logic [prw3x3_pkg::FHEIGHT_W-1:0] frame_height_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          valid_s1;
	logic [PW-1:0] pixel_s1;
	logic [CW-1:0] col_s1;
	logic          interior_s1;
	logic          last_s1;
	logic          hit_s1;
	logic [PW-1:0] byp_top_s1;
	logic [PW-1:0] byp_mid_s1;

	logic [PW-1:0] win_q [6];

	logic          out_valid_q;
	logic [PW-1:0] out_data_q;
	logic          out_last_q;

	logic          in_acc;
	logic          s1_go;
	logic [ZW-1:0] w_raw, h_raw, w_clamp, h_clamp;
	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic          row_end, frame_end;
	logic [PW-1:0] ram_top, ram_mid, top_eff, mid_eff;
	logic [SW-1:0] sum;
	logic [PW-1:0] edge_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= prw3x3_pkg::RST_FRAME_WIDTH;
			frame_height_q <= prw3x3_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				prw3x3_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[prw3x3_pkg::FWIDTH_W-1:0];
				prw3x3_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped frame size
	always_comb begin
		w_raw = ZW'(frame_width_q);
		h_raw = ZW'(frame_height_q);
		if (w_raw < ZW'(prw3x3_pkg::MIN_SIZE)) begin
			w_clamp = ZW'(prw3x3_pkg::MIN_SIZE);
		end else if (w_raw > ZW'(MAX_WIDTH)) begin
			w_clamp = ZW'(MAX_WIDTH);
		end else begin
			w_clamp = w_raw;
		end
		if (h_raw < ZW'(prw3x3_pkg::MIN_SIZE)) begin
			h_clamp = ZW'(prw3x3_pkg::MIN_SIZE);
		end else if (h_raw > ZW'(prw3x3_pkg::HEIGHT_LIMIT)) begin
			h_clamp = ZW'(prw3x3_pkg::HEIGHT_LIMIT);
		end else begin
			h_clamp = h_raw;
		end
	end

	assign s1_go         = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign col_cur   = s_axis_tuser ? '0 : col_q;
	assign row_cur   = s_axis_tuser ? '0 : row_q;
	assign row_end   = ZW'(col_cur) >= (w_clamp - ZW'(1));
	assign frame_end = ZW'(row_cur) >= (h_clamp - ZW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_cur + RW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
			end
		end
	end

	prw3x3_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_line_two (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata (mid_eff),
		.re    (in_acc),
		.raddr (col_cur),
		.rdata (ram_top)
	);

	prw3x3_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_line_one (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (in_acc),
		.raddr (col_cur),
		.rdata (ram_mid)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1    <= s_axis_tdata;
			col_s1      <= col_cur;
			interior_s1 <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
			last_s1     <= row_end && frame_end;
			// same column written back in this cycle
			hit_s1      <= s1_go && (col_cur == col_s1);
			byp_top_s1  <= mid_eff;
			byp_mid_s1  <= pixel_s1;
		end
	end

	assign top_eff = hit_s1 ? byp_top_s1 : ram_top;
	assign mid_eff = hit_s1 ? byp_mid_s1 : ram_mid;

	// window columns: [0..2] oldest column top/mid/bottom, [3..5] next column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_go) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_eff;
			win_q[4] <= mid_eff;
			win_q[5] <= pixel_s1;
		end
	end

	// horizontal plus vertical response reduces to this
	assign sum = (SW'(top_eff) << 1) + SW'(win_q[3]) + SW'(mid_eff)
		- (SW'(win_q[2]) << 1) - SW'(win_q[5]) - SW'(win_q[1]);

	assign edge_val = (sum[SW-1] || (sum[SW-2:PW] != '0)) ? PW'(255) : sum[PW-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && interior_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && interior_s1) begin
			out_data_q <= edge_val;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/prw3x3_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module prw3x3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_prewitt_3x3_edge_filter_top.sv =====
// testbench for prewitt_3x3_edge_filter_top: random and directed pixel frames,
// a bit-exact predictor of the edge stream and an in-order result check
// depends on prw3x3_pkg and the filter rtl only
`default_nettype none

module tb_prewitt_3x3_edge_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W          = prw3x3_pkg::DEF_MAX_WIDTH;
	localparam int DW             = prw3x3_pkg::CFG_DATA_W;
	localparam int CYCLE_LIMIT    = 4_000_000;
	localparam int RANDOM_PIXELS  = 200;
	localparam int SETTLE_CYCLES  = 4;

	typedef enum int {
		PIX_UNIFORM,
		PIX_EXTREME,
		PIX_SMOOTH
	} pixel_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} edge_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	prw3x3_pkg::cfg_idx_t  cfg_index     = prw3x3_pkg::CFG_FRAME_WIDTH;
	logic [DW-1:0]         cfg_data      = '0;

	prewitt_3x3_edge_filter_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// predictor state
	logic [prw3x3_pkg::FWIDTH_W-1:0]  width_reg  = prw3x3_pkg::RST_FRAME_WIDTH;
	logic [prw3x3_pkg::FHEIGHT_W-1:0] height_reg = prw3x3_pkg::RST_FRAME_HEIGHT;
	bit [7:0]             row_above1 [MAX_W];
	bit [7:0]             row_above2 [MAX_W];
	int                   window [6];
	int                   next_col = 0;
	int                   next_row = 0;

	edge_result_t expected_edges [$];
	edge_result_t want_edge;
	edge_result_t seen_edge;

	int  mismatches   = 0;
	int  results_seen = 0;
	int  sent_pixels  = 0;
	int  cycles       = 0;
	int  pixel_base   = 0;
	int  ready_hold   = 0;
	bit  idle_on      = 1'b1;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			ready_hold = int'($urandom_range(1, 19)) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic void report_mismatch(input string what, input edge_result_t want,
			input edge_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d %s: edge_res exp %0d got %0d, tlast exp %0b got %0b",
				results_seen, what, want.value, got.value, want.last, got.last);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_edge.value = m_axis_tdata;
			seen_edge.last  = m_axis_tlast;
			if (expected_edges.size() == 0) begin
				report_mismatch("unexpected", '0, seen_edge);
			end else begin
				want_edge = expected_edges.pop_front();
				if (want_edge !== seen_edge)
					report_mismatch("wrong", want_edge, seen_edge);
			end
			results_seen++;
		end
	end

	function automatic int eff_width();
		if (width_reg < prw3x3_pkg::MIN_SIZE)
			return prw3x3_pkg::MIN_SIZE;
		return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg < prw3x3_pkg::MIN_SIZE)
			return prw3x3_pkg::MIN_SIZE;
		return (height_reg > prw3x3_pkg::HEIGHT_LIMIT) ? prw3x3_pkg::HEIGHT_LIMIT
			: int'(height_reg);
	endfunction

	function automatic void predict_edge(input logic [7:0] px, input logic fs);
		int w, h, col, row, top, mid, p, s;
		edge_result_t r;
		w = eff_width();
		h = eff_height();
		if (fs) begin
			next_col = 0;
			next_row = 0;
		end
		col = next_col;
		row = next_row;
		p   = int'(px);
		top = int'(row_above2[col]);
		mid = int'(row_above1[col]);
		if (row >= 2 && col >= 2) begin
			s = (window[0] + window[3] + top) - (window[2] + window[5] + p)
				+ (top + mid + p) - (window[0] + window[1] + window[2]);
			r.value = (s < 0 || s > 255) ? 8'd255 : s[7:0];
			r.last  = (row >= h - 1 && col >= w - 1);
			expected_edges.push_back(r);
		end
		window[0] = window[3];
		window[1] = window[4];
		window[2] = window[5];
		window[3] = top;
		window[4] = mid;
		window[5] = p;
		row_above2[col] = 8'(mid);
		row_above1[col] = px;
		if (col >= w - 1) begin
			next_col = 0;
			next_row = (row >= h - 1) ? 0 : row + 1;
		end else begin
			next_col = col + 1;
		end
	endfunction

	function automatic logic [7:0] rand_pixel(input pixel_mode_t mode);
		int v;
		case (mode)
			PIX_UNIFORM: v = int'($urandom_range(0, 255));
			PIX_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
			default:     v = pixel_base + int'($urandom_range(0, 24)) - 12;
		endcase
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	task automatic send_pixel(input logic [7:0] px, input logic fs);
		int gap;
		gap = (idle_on && $urandom_range(0, 9) == 0) ? int'($urandom_range(1, 19)) : 0;
		if (gap > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= fs;
		do @(posedge clk); while (!s_axis_tready);
		predict_edge(px, fs);
		sent_pixels++;
	endtask

	task automatic send_frame(input bit fs, input pixel_mode_t mode);
		int n;
		n = eff_width() * eff_height();
		pixel_base = int'($urandom_range(0, 255));
		for (int i = 0; i < n; i++)
			send_pixel(rand_pixel(mode), fs && i == 0);
	endtask

	// stream drained and pipeline settled
	task automatic wait_quiet();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (expected_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input prw3x3_pkg::cfg_idx_t idx, input logic [DW-1:0] val);
		wait_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == prw3x3_pkg::CFG_FRAME_WIDTH)
			width_reg = val[prw3x3_pkg::FWIDTH_W-1:0];
		else
			height_reg = val[prw3x3_pkg::FHEIGHT_W-1:0];
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic test_default_size();
		idle_on = 1'b1;
		send_frame(1'b1, PIX_UNIFORM);
	endtask

	// 3x3 frames: exact 255, negative sum, sum above 255
	task automatic test_clipping();
		bit [7:0] pats [0:2][0:8] = '{
			'{8'd0,   8'd255, 8'd0,   8'd0, 8'd0, 8'd0, 8'd0,   8'd0,   8'd0},
			'{8'd0,   8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255},
			'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,   8'd0,   8'd0}
		};
		idle_on = 1'b1;
		write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(0));
		write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(2));
		for (int f = 0; f < 3; f++)
			for (int i = 0; i < 9; i++)
				send_pixel(pats[f][i], f != 1 && i == 0);
	endtask

	task automatic test_size_extremes();
		idle_on = 1'b1;
		write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(0));
		write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(0));
		send_frame(1'b1, PIX_UNIFORM);
		write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(2));
		write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(1));
		send_frame(1'b1, PIX_EXTREME);
		write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(3));
		write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(3));
		send_frame(1'b0, PIX_SMOOTH);
	endtask

	// counters left beyond a shrunk width, then a shrunk height
	task automatic test_shrink_mid_frame();
		idle_on = 1'b1;
		write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(10));
		write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(10));
		for (int i = 0; i < 57; i++)
			send_pixel(rand_pixel(PIX_UNIFORM), i == 0);
		write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(4));
		for (int i = 0; i < 5; i++)
			send_pixel(rand_pixel(PIX_UNIFORM), 1'b0);
		write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(5));
		for (int i = 0; i < 4; i++)
			send_pixel(rand_pixel(PIX_UNIFORM), 1'b0);
		send_frame(1'b0, PIX_SMOOTH);
	endtask

	task automatic test_random_frames();
		int start_count, w, h;
		start_count = sent_pixels;
		idle_on = 1'b1;
		while (sent_pixels - start_count < RANDOM_PIXELS) begin
			if (sent_pixels - start_count >= RANDOM_PIXELS * 3 / 4)
				idle_on = 1'b0;
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0:       w = int'($urandom_range(0, 2));
					1:       w = int'($urandom_range(16, 24));
					default: w = int'($urandom_range(3, 12));
				endcase
				h = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 2))
					: int'($urandom_range(3, 6));
				write_reg(prw3x3_pkg::CFG_FRAME_WIDTH, DW'(w));
				write_reg(prw3x3_pkg::CFG_FRAME_HEIGHT, DW'(h));
			end
			send_frame($urandom_range(0, 3) != 0, pixel_mode_t'($urandom_range(0, 2)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_default_size();
		test_clipping();
		test_size_extremes();
		test_shrink_mid_frame();
		test_random_frames();
		wait_quiet();
		if (mismatches == 0 && expected_edges.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/prw3x3_pkg.sv
hw/rtl/prw3x3_ram.sv
hw/rtl/prewitt_3x3_edge_filter_top.sv
bench/tb_prewitt_3x3_edge_filter_top.sv
